// ===== hdl/zpcd_pkg.sv =====
// zpcd_pkg: shared types, constants and codes of the z-score phase change detector
// no dependencies; every other file of the block but zpcd_ram refers to it by scoped names
`default_nettype none
package zpcd_pkg;

	// defaults for top level parameters
	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 24;

	// fixed widths
	localparam int NCH       = 3;
	localparam int CH_W      = 2;
	localparam int IN_W      = 24;
	localparam int FRAC_W    = 16;
	localparam int XW        = IN_W + FRAC_W;  // Q24.16 sample and mean
	localparam int SUM_W     = 64;
	localparam int ACC_W     = 2 * XW;
	localparam int PROD_SH   = 24;
	localparam int DVD_W     = SUM_W + 8;      // dividend of the shared divider
	localparam int DVS_W     = 32;             // divisor of the shared divider
	localparam int ROOT_W    = 32;
	localparam int ZW        = 16;
	localparam int ZABS_W    = ZW + 1;
	localparam int CNT_W     = 16;
	localparam int THR_W     = 15;
	localparam int WL_W      = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 15;

	localparam logic [THR_W-1:0] THR_RESET = 15'd768;
	localparam logic [WL_W-1:0]  WL_RESET  = 7'd8;
	localparam logic [DVS_W-1:0] STD_ONE   = 32'd256;
	localparam logic [ZW-1:0]    Z_POS_MAX = 16'h7FFF;
	localparam logic [ZW-1:0]    Z_NEG_MAX = 16'h8000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_Z_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

	// trend codes
	localparam logic [1:0] TREND_INSUF  = 2'd0;
	localparam logic [1:0] TREND_INC    = 2'd1;
	localparam logic [1:0] TREND_DEC    = 2'd2;
	localparam logic [1:0] TREND_STABLE = 2'd3;

	typedef struct packed {
		logic [IN_W-1:0] cycles_sample;
		logic [IN_W-1:0] instructions_sample;
		logic [IN_W-1:0] l2_miss_sample;
		logic [31:0]     sample_time;
		logic [15:0]     clock_frequency;
	} in_item_t;

	typedef struct packed {
		logic                 transition_seen;
		logic signed [ZW-1:0] z_cycles;
		logic signed [ZW-1:0] z_instructions;
		logic signed [ZW-1:0] z_l2_miss;
		logic [1:0]           trend_cycles;
		logic [1:0]           trend_instructions;
		logic [1:0]           trend_l2_miss;
		logic [31:0]          time_out;
		logic [15:0]          frequency_out;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DELTA, ST_DIV_MEAN, ST_WAIT_MEAN, ST_MEAN, ST_D2,
		ST_MUL_LO, ST_MUL_HI, ST_SUM, ST_DIV_VAR, ST_WAIT_VAR, ST_SQRT,
		ST_WAIT_SQRT, ST_DIV_Z, ST_WAIT_Z, ST_ZSTORE, ST_TR_WR, ST_TR_RD,
		ST_TR_CMP, ST_NEXT, ST_FIN
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_DELTA, OP_DIV_MEAN, OP_MEAN, OP_D2, OP_MUL_LO,
		OP_MUL_HI, OP_SUM, OP_DIV_VAR, OP_SQRT, OP_DIV_Z, OP_ZSTORE,
		OP_TR_WR, OP_TR_RD, OP_TR_CMP, OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic [CH_W-1:0] ch;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic few_samples;
		logic short_win;
		logic tr_last;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/zscore_phase_change_detector.sv =====
// zscore_phase_change_detector: top level joining the sequencer and the datapath
// depends on zpcd_pkg, zpcd_ctrl and zpcd_dp
//
// Each input beat carries three counter samples. Per channel the block keeps a
// running mean (Q24.16) and sum of squared deviations, and returns one result beat
// with the saturated Q7.8 z-score of every channel, a trend over the last
// window_length samples and a transition flag when the largest |z| exceeds
// z_threshold; timestamp and frequency tag are copied through. One item is worked
// at a time. The channels go one after another through a single bit serial
// divider (three passes a channel once two samples have been seen, else one)
// and a two bit a cycle square root, then a trend scan over the window, whose
// length is capped at MAX_WINDOW. The next item is taken as soon as the previous
// result sits in the output register. The window starts as zeros through a fill
// count, so no clearing pass follows reset. Configuration writes are taken at any
// cycle and belong to idle periods.
`default_nettype none
module zscore_phase_change_detector #(
	parameter int MAX_WINDOW  = zpcd_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = zpcd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire zpcd_pkg::in_item_t             in_item,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output zpcd_pkg::out_item_t                 out_item,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [zpcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [zpcd_pkg::CFG_DAT_W-1:0] cfg_data
);

	zpcd_pkg::dp_cmd_t    cmd;
	zpcd_pkg::dp_status_t sts;

	assign cfg_ready = 1'b1;

	zpcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	zpcd_dp #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	// an accepted beat keeps the input side closed while it is worked
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item was in progress");

	// the shared divider is never restarted while it runs
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == zpcd_pkg::OP_DIV_MEAN || cmd.op == zpcd_pkg::OP_DIV_VAR ||
		 cmd.op == zpcd_pkg::OP_DIV_Z) |-> !sts.div_busy)
		else $error("divider started while busy");

	// a result appears only after the sequencer finished an item
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.op == zpcd_pkg::OP_FIN))
		else $error("result beat without a finished item");

	// a finished item is never written over a result that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == zpcd_pkg::OP_FIN) |-> (!out_valid || !out_stall))
		else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire

// ===== hdl/zpcd_ram.sv =====
// zpcd_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module zpcd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/zpcd_div.sv =====
// zpcd_div: bit serial unsigned restoring divider, one quotient bit per cycle
// depends on zpcd_pkg for widths
`default_nettype none
module zpcd_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [zpcd_pkg::DVD_W-1:0] dividend,
	input  wire logic [zpcd_pkg::DVS_W-1:0] divisor,
	output logic                            busy,
	output logic      [zpcd_pkg::DVD_W-1:0] quot
);

	localparam int DW = zpcd_pkg::DVD_W;
	localparam int SW = zpcd_pkg::DVS_W;
	localparam int CW = $clog2(DW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [SW:0]   sh;
	logic          ge;
	logic [SW:0]   diff;

	// one restoring step
	assign sh   = {rem_q, quo_q[DW-1]};
	assign ge   = sh >= {1'b0, dvs_q};
	assign diff = sh - {1'b0, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[SW-1:0] : sh[SW-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

// ===== hdl/zpcd_sqrt.sv =====
// zpcd_sqrt: iterative integer square root, two radicand bits per cycle
// depends on zpcd_pkg for widths
`default_nettype none
module zpcd_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [zpcd_pkg::SUM_W-1:0]  radicand,
	output logic                             busy,
	output logic      [zpcd_pkg::ROOT_W-1:0] root
);

	localparam int VW = zpcd_pkg::SUM_W;

	logic          busy_q;
	logic [VW-1:0] v_q;
	logic [VW-1:0] r_q;
	logic [VW-1:0] bit_q;
	logic [VW-1:0] trial;

	assign trial = r_q + bit_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	// one digit step
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= VW'(1) << (VW - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[zpcd_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== hdl/zpcd_ctrl.sv =====
// zpcd_ctrl: sequencer that walks the three channels through update, z-score and trend
// depends on zpcd_pkg for states, datapath commands and status
`default_nettype none
module zpcd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire zpcd_pkg::dp_status_t sts,
	output zpcd_pkg::dp_cmd_t         cmd
);

	localparam int CHW = zpcd_pkg::CH_W;

	zpcd_pkg::state_t state_q, state_n;
	logic [CHW-1:0]   ch_q;
	logic             last_ch;

	assign last_ch = ch_q == CHW'(zpcd_pkg::NCH - 1);

	// state and channel registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zpcd_pkg::ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == zpcd_pkg::ST_IDLE) begin
				ch_q <= '0;
			end else if (state_q == zpcd_pkg::ST_NEXT && !last_ch) begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			zpcd_pkg::ST_IDLE:      if (in_valid) state_n = zpcd_pkg::ST_DELTA;
			zpcd_pkg::ST_DELTA:     state_n = zpcd_pkg::ST_DIV_MEAN;
			zpcd_pkg::ST_DIV_MEAN:  state_n = zpcd_pkg::ST_WAIT_MEAN;
			zpcd_pkg::ST_WAIT_MEAN: if (!sts.div_busy) state_n = zpcd_pkg::ST_MEAN;
			zpcd_pkg::ST_MEAN:      state_n = zpcd_pkg::ST_D2;
			zpcd_pkg::ST_D2:        state_n = zpcd_pkg::ST_MUL_LO;
			zpcd_pkg::ST_MUL_LO:    state_n = zpcd_pkg::ST_MUL_HI;
			zpcd_pkg::ST_MUL_HI:    state_n = zpcd_pkg::ST_SUM;
			zpcd_pkg::ST_SUM: begin
				state_n = sts.few_samples ? zpcd_pkg::ST_TR_WR : zpcd_pkg::ST_DIV_VAR;
			end
			zpcd_pkg::ST_DIV_VAR:   state_n = zpcd_pkg::ST_WAIT_VAR;
			zpcd_pkg::ST_WAIT_VAR:  if (!sts.div_busy) state_n = zpcd_pkg::ST_SQRT;
			zpcd_pkg::ST_SQRT:      state_n = zpcd_pkg::ST_WAIT_SQRT;
			zpcd_pkg::ST_WAIT_SQRT: if (!sts.sqrt_busy) state_n = zpcd_pkg::ST_DIV_Z;
			zpcd_pkg::ST_DIV_Z:     state_n = zpcd_pkg::ST_WAIT_Z;
			zpcd_pkg::ST_WAIT_Z:    if (!sts.div_busy) state_n = zpcd_pkg::ST_ZSTORE;
			zpcd_pkg::ST_ZSTORE:    state_n = zpcd_pkg::ST_TR_WR;
			zpcd_pkg::ST_TR_WR: begin
				state_n = sts.short_win ? zpcd_pkg::ST_NEXT : zpcd_pkg::ST_TR_RD;
			end
			zpcd_pkg::ST_TR_RD:     state_n = zpcd_pkg::ST_TR_CMP;
			zpcd_pkg::ST_TR_CMP: begin
				state_n = sts.tr_last ? zpcd_pkg::ST_NEXT : zpcd_pkg::ST_TR_RD;
			end
			zpcd_pkg::ST_NEXT: begin
				state_n = last_ch ? zpcd_pkg::ST_FIN : zpcd_pkg::ST_DELTA;
			end
			zpcd_pkg::ST_FIN:       if (sts.out_free) state_n = zpcd_pkg::ST_IDLE;
			default:                state_n = zpcd_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd.ch   = ch_q;
		cmd.op   = zpcd_pkg::OP_NONE;
		in_stall = state_q != zpcd_pkg::ST_IDLE;
		unique case (state_q)
			zpcd_pkg::ST_IDLE:     if (in_valid) cmd.op = zpcd_pkg::OP_LOAD;
			zpcd_pkg::ST_DELTA:    cmd.op = zpcd_pkg::OP_DELTA;
			zpcd_pkg::ST_DIV_MEAN: cmd.op = zpcd_pkg::OP_DIV_MEAN;
			zpcd_pkg::ST_MEAN:     cmd.op = zpcd_pkg::OP_MEAN;
			zpcd_pkg::ST_D2:       cmd.op = zpcd_pkg::OP_D2;
			zpcd_pkg::ST_MUL_LO:   cmd.op = zpcd_pkg::OP_MUL_LO;
			zpcd_pkg::ST_MUL_HI:   cmd.op = zpcd_pkg::OP_MUL_HI;
			zpcd_pkg::ST_SUM:      cmd.op = zpcd_pkg::OP_SUM;
			zpcd_pkg::ST_DIV_VAR:  cmd.op = zpcd_pkg::OP_DIV_VAR;
			zpcd_pkg::ST_SQRT:     cmd.op = zpcd_pkg::OP_SQRT;
			zpcd_pkg::ST_DIV_Z:    cmd.op = zpcd_pkg::OP_DIV_Z;
			zpcd_pkg::ST_ZSTORE:   cmd.op = zpcd_pkg::OP_ZSTORE;
			zpcd_pkg::ST_TR_WR:    cmd.op = zpcd_pkg::OP_TR_WR;
			zpcd_pkg::ST_TR_RD:    cmd.op = zpcd_pkg::OP_TR_RD;
			zpcd_pkg::ST_TR_CMP:   cmd.op = zpcd_pkg::OP_TR_CMP;
			zpcd_pkg::ST_FIN:      if (sts.out_free) cmd.op = zpcd_pkg::OP_FIN;
			zpcd_pkg::ST_WAIT_MEAN, zpcd_pkg::ST_WAIT_VAR, zpcd_pkg::ST_WAIT_SQRT,
			zpcd_pkg::ST_WAIT_Z, zpcd_pkg::ST_NEXT: cmd.op = zpcd_pkg::OP_NONE;
			default:               cmd.op = zpcd_pkg::OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/zpcd_dp.sv =====
// zpcd_dp: per channel statistics, shared divider, square root, multiplier and trend window
// depends on zpcd_pkg, zpcd_div, zpcd_sqrt and zpcd_ram
`default_nettype none
module zpcd_dp #(
	parameter int MAX_WINDOW  = zpcd_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = zpcd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire zpcd_pkg::in_item_t             in_item,
	input  wire logic                           cfg_valid,
	input  wire logic [zpcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [zpcd_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire zpcd_pkg::dp_cmd_t              cmd,
	output zpcd_pkg::dp_status_t                sts,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output zpcd_pkg::out_item_t                 out_item
);

	localparam int NCH    = zpcd_pkg::NCH;
	localparam int IN_W   = zpcd_pkg::IN_W;
	localparam int XW     = zpcd_pkg::XW;
	localparam int SUM_W  = zpcd_pkg::SUM_W;
	localparam int ACC_W  = zpcd_pkg::ACC_W;
	localparam int HALF_W = XW / 2;
	localparam int ZW     = zpcd_pkg::ZW;
	localparam int ZAW    = zpcd_pkg::ZABS_W;
	localparam int CNT_W  = zpcd_pkg::CNT_W;
	localparam int EB     = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
	localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int AD_W   = $clog2(NCH * MAX_WINDOW);
	localparam int PW     = XW + HALF_W;

	// configuration
	logic [zpcd_pkg::THR_W-1:0] thr_q;
	logic [zpcd_pkg::WL_W-1:0]  wl_q;

	// item and channel state
	logic [IN_W-1:0]      smp_q   [NCH];
	logic [31:0]          time_q;
	logic [15:0]          freq_q;
	logic [CNT_W-1:0]     count_q;
	logic [XW-1:0]        mean_q  [NCH];
	logic [SUM_W-1:0]     m2_q    [NCH];
	logic signed [ZW-1:0] z_q     [NCH];
	logic [1:0]           trend_q [NCH];
	logic [ZAW-1:0]       maxabs_q;

	// working registers
	logic               dneg_q;
	logic [XW-1:0]      dmag_q;
	logic               d2neg_q;
	logic [XW-1:0]      d2mag_q;
	logic [ACC_W-1:0]   acc_q;
	logic               var_zero_q;

	// trend window
	logic [LEN_W-1:0]  age_q;
	logic [LEN_W-1:0]  fill_q;
	logic [SLOT_W-1:0] head_q;
	logic              up_q;
	logic              down_q;
	logic [EB-1:0]     prev_q;

	// output register
	logic                out_valid_q;
	zpcd_pkg::out_item_t out_q;

	// masked samples of the incoming beat
	logic [IN_W-1:0] smp_in [NCH];
	assign smp_in[0] = IN_W'(in_item.cycles_sample[EB-1:0]);
	assign smp_in[1] = IN_W'(in_item.instructions_sample[EB-1:0]);
	assign smp_in[2] = IN_W'(in_item.l2_miss_sample[EB-1:0]);

	// current channel operands
	logic [XW-1:0] x_cur;
	logic [XW-1:0] mean_cur;
	logic          x_lt_mean;
	logic [XW-1:0] abs_diff;
	assign x_cur     = {smp_q[cmd.ch], {zpcd_pkg::FRAC_W{1'b0}}};
	assign mean_cur  = mean_q[cmd.ch];
	assign x_lt_mean = x_cur < mean_cur;
	assign abs_diff  = x_lt_mean ? (mean_cur - x_cur) : (x_cur - mean_cur);

	// shared divider
	logic                       div_start;
	logic [zpcd_pkg::DVD_W-1:0] div_dvd;
	logic [zpcd_pkg::DVS_W-1:0] div_dvs;
	logic                       div_busy;
	logic [zpcd_pkg::DVD_W-1:0] div_quot;

	// square root
	logic                        sqrt_busy;
	logic [zpcd_pkg::ROOT_W-1:0] sqrt_root;
	logic [SUM_W-1:0]            var_w;
	assign var_w = (|div_quot[zpcd_pkg::DVD_W-1:SUM_W]) ? '1 : div_quot[SUM_W-1:0];

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_dvd   = zpcd_pkg::DVD_W'(dmag_q);
		div_dvs   = zpcd_pkg::DVS_W'(count_q);
		case (cmd.op)
			zpcd_pkg::OP_DIV_MEAN: begin
				div_start = 1'b1;
			end
			zpcd_pkg::OP_DIV_VAR: begin
				div_start = 1'b1;
				div_dvd   = {m2_q[cmd.ch], 8'd0};
				div_dvs   = zpcd_pkg::DVS_W'(count_q - 1'b1);
			end
			zpcd_pkg::OP_DIV_Z: begin
				div_start = 1'b1;
				div_dvd   = zpcd_pkg::DVD_W'(d2mag_q);
				div_dvs   = var_zero_q ? zpcd_pkg::STD_ONE : sqrt_root;
			end
			default: ;
		endcase
	end

	zpcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	zpcd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == zpcd_pkg::OP_SQRT),
		.radicand (var_w),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	// half width multiplier, low half then high half of the second operand
	logic [HALF_W-1:0] mul_b;
	logic [PW-1:0]     mul_p;
	assign mul_b = (cmd.op == zpcd_pkg::OP_MUL_HI) ? d2mag_q[XW-1:HALF_W] : d2mag_q[HALF_W-1:0];
	assign mul_p = dmag_q * mul_b;

	// saturating accumulate of the squared deviation
	logic [SUM_W:0] sum_w;
	assign sum_w = {1'b0, m2_q[cmd.ch]} + (SUM_W + 1)'(acc_q[ACC_W-1:zpcd_pkg::PROD_SH]);

	// saturated z-score from the quotient magnitude
	logic                 z_big;
	logic signed [ZW-1:0] z_val;
	logic [ZAW-1:0]       z_abs;
	always_comb begin
		z_big = |div_quot[zpcd_pkg::DVD_W-1:ZW-1];
		if (d2neg_q) begin
			z_val = z_big ? zpcd_pkg::Z_NEG_MAX : (ZW'(0) - {1'b0, div_quot[ZW-2:0]});
			z_abs = z_big ? ZAW'({1'b1, {(ZW-1){1'b0}}}) : ZAW'(div_quot[ZW-2:0]);
		end else begin
			z_val = z_big ? zpcd_pkg::Z_POS_MAX : {1'b0, div_quot[ZW-2:0]};
			z_abs = z_big ? ZAW'(zpcd_pkg::Z_POS_MAX) : ZAW'(div_quot[ZW-2:0]);
		end
	end

	// window geometry
	logic [LEN_W-1:0]  len;
	logic [LEN_W:0]    slot_x;
	logic [SLOT_W-1:0] slot;
	logic [AD_W-1:0]   base;
	logic [EB-1:0]     rdata;
	logic [EB-1:0]     older;
	logic              nup;
	logic              ndown;
	always_comb begin
		if (32'(wl_q) > MAX_WINDOW) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = LEN_W'(wl_q);
		end
		if ((LEN_W + 1)'(head_q) >= (LEN_W + 1)'(age_q)) begin
			slot_x = (LEN_W + 1)'(head_q) - (LEN_W + 1)'(age_q);
		end else begin
			slot_x = (LEN_W + 1)'(head_q) + (LEN_W + 1)'(MAX_WINDOW) - (LEN_W + 1)'(age_q);
		end
		slot  = slot_x[SLOT_W-1:0];
		base  = AD_W'(cmd.ch) * AD_W'(MAX_WINDOW);
		older = (age_q <= fill_q) ? rdata : '0;
		nup   = up_q && (prev_q > older);
		ndown = down_q && (prev_q < older);
	end

	zpcd_ram #(
		.WIDTH (EB),
		.DEPTH (NCH * MAX_WINDOW)
	) u_win (
		.clk   (clk),
		.we    (cmd.op == zpcd_pkg::OP_TR_WR),
		.waddr (base + AD_W'(head_q)),
		.wdata (smp_q[cmd.ch][EB-1:0]),
		.raddr (base + AD_W'(slot)),
		.rdata (rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= zpcd_pkg::THR_RESET;
			wl_q  <= zpcd_pkg::WL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				zpcd_pkg::CFG_Z_THRESHOLD:   thr_q <= cfg_data[zpcd_pkg::THR_W-1:0];
				zpcd_pkg::CFG_WINDOW_LENGTH: wl_q  <= cfg_data[zpcd_pkg::WL_W-1:0];
				default: ;
			endcase
		end
	end

	// statistics state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fill_q  <= '0;
			head_q  <= '0;
			for (int i = 0; i < NCH; i++) begin
				mean_q[i] <= '0;
				m2_q[i]   <= '0;
			end
		end else begin
			case (cmd.op)
				zpcd_pkg::OP_LOAD: begin
					if (count_q != '1) begin
						count_q <= count_q + 1'b1;
					end
				end
				zpcd_pkg::OP_MEAN: begin
					if (dneg_q) begin
						mean_q[cmd.ch] <= mean_cur - div_quot[XW-1:0];
					end else begin
						mean_q[cmd.ch] <= mean_cur + div_quot[XW-1:0];
					end
				end
				zpcd_pkg::OP_SUM: begin
					m2_q[cmd.ch] <= sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
				end
				zpcd_pkg::OP_FIN: begin
					head_q <= (32'(head_q) == MAX_WINDOW - 1) ? '0 : head_q + 1'b1;
					if (fill_q != LEN_W'(MAX_WINDOW)) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			zpcd_pkg::OP_LOAD: begin
				for (int i = 0; i < NCH; i++) begin
					smp_q[i] <= smp_in[i];
				end
				time_q   <= in_item.sample_time;
				freq_q   <= in_item.clock_frequency;
				maxabs_q <= '0;
			end
			zpcd_pkg::OP_DELTA: begin
				dneg_q <= x_lt_mean;
				dmag_q <= abs_diff;
			end
			zpcd_pkg::OP_D2: begin
				d2neg_q <= x_lt_mean;
				d2mag_q <= abs_diff;
			end
			zpcd_pkg::OP_MUL_LO: acc_q <= ACC_W'(mul_p);
			zpcd_pkg::OP_MUL_HI: acc_q <= acc_q + {mul_p, {HALF_W{1'b0}}};
			zpcd_pkg::OP_SUM:    z_q[cmd.ch] <= '0;
			zpcd_pkg::OP_SQRT:   var_zero_q <= var_w == '0;
			zpcd_pkg::OP_ZSTORE: begin
				z_q[cmd.ch] <= z_val;
				if (z_abs > maxabs_q) begin
					maxabs_q <= z_abs;
				end
			end
			zpcd_pkg::OP_TR_WR: begin
				age_q          <= LEN_W'(1);
				up_q           <= 1'b1;
				down_q         <= 1'b1;
				prev_q         <= smp_q[cmd.ch][EB-1:0];
				trend_q[cmd.ch] <= zpcd_pkg::TREND_INSUF;
			end
			zpcd_pkg::OP_TR_CMP: begin
				up_q   <= nup;
				down_q <= ndown;
				prev_q <= older;
				age_q  <= age_q + 1'b1;
				if (sts.tr_last) begin
					trend_q[cmd.ch] <= nup ? zpcd_pkg::TREND_INC :
						(ndown ? zpcd_pkg::TREND_DEC : zpcd_pkg::TREND_STABLE);
				end
			end
			default: ;
		endcase
	end

	// result register, freed when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == zpcd_pkg::OP_FIN) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == zpcd_pkg::OP_FIN) begin
			out_q.transition_seen    <= maxabs_q > ZAW'(thr_q);
			out_q.z_cycles           <= z_q[0];
			out_q.z_instructions     <= z_q[1];
			out_q.z_l2_miss          <= z_q[2];
			out_q.trend_cycles       <= trend_q[0];
			out_q.trend_instructions <= trend_q[1];
			out_q.trend_l2_miss      <= trend_q[2];
			out_q.time_out           <= time_q;
			out_q.frequency_out      <= freq_q;
		end
	end

	// status to the sequencer
	assign sts.div_busy    = div_busy;
	assign sts.sqrt_busy   = sqrt_busy;
	assign sts.few_samples = count_q < CNT_W'(2);
	assign sts.short_win   = len < LEN_W'(2);
	assign sts.tr_last     = age_q == (len - 1'b1);
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

// ===== verif/tb_zscore_phase_change_detector.sv =====
// tb_zscore_phase_change_detector: self-checking bench for the z-score phase change detector
// depends on zpcd_pkg and zscore_phase_change_detector; runs a directed table, then random
// phases under several register settings, results checked against a built-in predictor or a fixed row
`default_nettype none
module tb_zscore_phase_change_detector;

	localparam int CYCLE_LIMIT  = 9000000;
	localparam int ITEM_CYCLES  = 1300;   // above the slowest item, window at its maximum
	localparam int WIN_DEPTH    = 64;
	localparam int HOLD_CYCLES  = 4000;

	localparam int NCH       = zpcd_pkg::NCH;
	localparam int IN_W      = zpcd_pkg::IN_W;
	localparam int ZW        = zpcd_pkg::ZW;
	localparam int THR_W     = zpcd_pkg::THR_W;
	localparam int WL_W      = zpcd_pkg::WL_W;
	localparam int CFG_IDX_W = zpcd_pkg::CFG_IDX_W;
	localparam int CFG_DAT_W = zpcd_pkg::CFG_DAT_W;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	zpcd_pkg::in_item_t   in_item;
	logic                 out_valid;
	logic                 out_stall;
	zpcd_pkg::out_item_t  out_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	zscore_phase_change_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [THR_W-1:0]  thr_reg;
	logic [WL_W-1:0]   wlen_reg;
	int unsigned       n_seen;
	longint            mean_q16 [NCH];
	logic [63:0]       sqdev_sum [NCH];
	logic [IN_W-1:0]   history [NCH][WIN_DEPTH];

	zpcd_pkg::out_item_t pending_results[$];
	int                n_errors;
	bit                idle_off;
	bit                hold_req;

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 64'd0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// welford update of one channel, returns the saturated q7.8 z-score
	function automatic logic signed [ZW-1:0] update_zscore(int ch, logic [IN_W-1:0] s);
		longint      x, d1, d2, diff, z;
		logic [63:0] a1, a2, var_q16, sd, q, r, dv;
		logic [127:0] p;
		logic [64:0] acc;
		x = longint'({40'd0, s}) <<< 16;
		d1 = x - mean_q16[ch];
		mean_q16[ch] = mean_q16[ch] + d1 / longint'(n_seen);
		d2 = x - mean_q16[ch];
		a1 = (d1 < 0) ? -d1 : d1;
		a2 = (d2 < 0) ? -d2 : d2;
		p = {64'd0, a1} * {64'd0, a2};
		p = p >> 24;
		if (p[127:64] != 64'd0)
			p[63:0] = '1;
		acc = {1'b0, sqdev_sum[ch]} + {1'b0, p[63:0]};
		sqdev_sum[ch] = acc[64] ? '1 : acc[63:0];
		if (n_seen < 2)
			return '0;
		dv = 64'(n_seen - 1);
		q = sqdev_sum[ch] / dv;
		r = sqdev_sum[ch] % dv;
		if ((q >> 56) != 64'd0)
			var_q16 = '1;
		else
			var_q16 = (q << 8) + (r << 8) / dv;
		sd = (var_q16 == 64'd0) ? 64'd256 : floor_sqrt(var_q16);
		if (sd == 64'd0)
			sd = 64'd256;
		diff = x - mean_q16[ch];
		z = diff / longint'(sd);
		if (z > 32767)
			z = 32767;
		if (z < -32768)
			z = -32768;
		return z[ZW-1:0];
	endfunction

	// shift the sample into the history and classify the window
	function automatic logic [1:0] update_trend(int ch, logic [IN_W-1:0] s);
		int  len;
		bit  up, down;
		up = 1'b1;
		down = 1'b1;
		for (int k = WIN_DEPTH - 1; k > 0; k--)
			history[ch][k] = history[ch][k-1];
		history[ch][0] = s;
		len = (wlen_reg > WIN_DEPTH) ? WIN_DEPTH : int'(wlen_reg);
		if (len < 2)
			return zpcd_pkg::TREND_INSUF;
		for (int k = len - 1; k >= 1; k--) begin
			if (!(history[ch][k-1] > history[ch][k]))
				up = 1'b0;
			if (!(history[ch][k-1] < history[ch][k]))
				down = 1'b0;
		end
		if (up)
			return zpcd_pkg::TREND_INC;
		if (down)
			return zpcd_pkg::TREND_DEC;
		return zpcd_pkg::TREND_STABLE;
	endfunction

	function automatic zpcd_pkg::out_item_t predict_detection(zpcd_pkg::in_item_t it);
		zpcd_pkg::out_item_t  res;
		logic [IN_W-1:0]      s [NCH];
		logic signed [ZW-1:0] z [NCH];
		logic [1:0]           tr [NCH];
		int                   mx, a;
		s[0] = it.cycles_sample;
		s[1] = it.instructions_sample;
		s[2] = it.l2_miss_sample;
		mx = 0;
		if (n_seen < 65535)
			n_seen++;
		for (int ch = 0; ch < NCH; ch++) begin
			z[ch] = update_zscore(ch, s[ch]);
			a = (z[ch] < 0) ? -int'(z[ch]) : int'(z[ch]);
			if (a > mx)
				mx = a;
			tr[ch] = update_trend(ch, s[ch]);
		end
		res.transition_seen    = (mx > int'(thr_reg));
		res.z_cycles           = z[0];
		res.z_instructions     = z[1];
		res.z_l2_miss          = z[2];
		res.trend_cycles       = tr[0];
		res.trend_instructions = tr[1];
		res.trend_l2_miss      = tr[2];
		res.time_out           = it.sample_time;
		res.frequency_out      = it.clock_frequency;
		return res;
	endfunction

	// input beat: hold until accepted, then record the expected detection
	task automatic send_sample(zpcd_pkg::in_item_t it, bit has_fixed,
		zpcd_pkg::out_item_t fixed_res);
		zpcd_pkg::out_item_t pred;
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		pred = predict_detection(it);
		pending_results.insert(pending_results.size(), has_fixed ? fixed_res : pred);
		if (!idle_off && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// one register write, with the valid line dropped before the next one
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == zpcd_pkg::CFG_Z_THRESHOLD)
			thr_reg = val[THR_W-1:0];
		else if (idx == zpcd_pkg::CFG_WINDOW_LENGTH)
			wlen_reg = val[WL_W-1:0];
		@(posedge clk);
	endtask

	// let every expected beat drain, then give the block time to settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (ITEM_CYCLES) @(posedge clk);
	endtask

	// receiver side: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!idle_off && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(string fname, longint want, longint got);
		if (want != got) begin
			n_errors++;
			if (n_errors <= 10)
				$display("mismatch %s: expected %0d, got %0d", fname, want, got);
		end
	endtask

	// result beat check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			zpcd_pkg::out_item_t want;
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("mismatch: result beat with nothing expected");
			end else begin
				want = pending_results.pop_front();
				check_field("transition_seen", want.transition_seen, out_item.transition_seen);
				check_field("z_cycles", want.z_cycles, out_item.z_cycles);
				check_field("z_instructions", want.z_instructions, out_item.z_instructions);
				check_field("z_l2_miss", want.z_l2_miss, out_item.z_l2_miss);
				check_field("trend_cycles", want.trend_cycles, out_item.trend_cycles);
				check_field("trend_instructions", want.trend_instructions,
					out_item.trend_instructions);
				check_field("trend_l2_miss", want.trend_l2_miss, out_item.trend_l2_miss);
				check_field("time_out", want.time_out, out_item.time_out);
				check_field("frequency_out", want.frequency_out, out_item.frequency_out);
			end
		end
	end

	// watchdog
	initial begin
		int cyc;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic zpcd_pkg::in_item_t make_item(logic [IN_W-1:0] c, logic [IN_W-1:0] i,
		logic [IN_W-1:0] m, logic [31:0] t, logic [15:0] f);
		zpcd_pkg::in_item_t it;
		it.cycles_sample       = c;
		it.instructions_sample = i;
		it.l2_miss_sample      = m;
		it.sample_time         = t;
		it.clock_frequency     = f;
		return it;
	endfunction

	// one counter sample of a phase: steady level with noise, ramps, spikes, or anything
	function automatic logic [IN_W-1:0] phase_sample(int kind, logic [IN_W-1:0] lvl,
		int noise_bits, int step);
		logic [IN_W-1:0] v;
		case (kind)
			0: v = lvl + IN_W'($urandom & ((1 << noise_bits) - 1));
			1: v = lvl + IN_W'(step);
			2: v = lvl - IN_W'(step);
			default: v = IN_W'($urandom);
		endcase
		if ($urandom_range(0, 40) == 0)
			v = IN_W'($urandom);
		return v;
	endfunction

	typedef struct {
		zpcd_pkg::in_item_t  it;
		bit                  has_fixed;
		zpcd_pkg::out_item_t fixed_res;
	} table_row_t;

	initial begin
		table_row_t  rows[$];
		table_row_t  row;
		zpcd_pkg::out_item_t none;
		logic [IN_W-1:0] lvl [NCH];
		int          kind, noise_bits, n_sent, plen;
		logic [CFG_DAT_W-1:0] thr_set [6];
		logic [CFG_DAT_W-1:0] wl_set [6];

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = zpcd_pkg::CFG_Z_THRESHOLD;
		cfg_data  = '0;
		idle_off  = 1'b0;
		hold_req  = 1'b0;
		n_errors  = 0;
		thr_reg   = zpcd_pkg::THR_RESET;
		wlen_reg  = zpcd_pkg::WL_RESET;
		n_seen    = 0;
		for (int ch = 0; ch < NCH; ch++) begin
			mean_q16[ch]  = 0;
			sqdev_sum[ch] = '0;
			for (int k = 0; k < WIN_DEPTH; k++)
				history[ch][k] = '0;
		end
		none = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; first row reads off directly: one sample gives zero scores
		row.it = make_item('0, '0, '0, 32'd0, 16'd0);
		row.has_fixed = 1'b1;
		row.fixed_res = '0;
		row.fixed_res.trend_cycles = zpcd_pkg::TREND_STABLE;
		row.fixed_res.trend_instructions = zpcd_pkg::TREND_STABLE;
		row.fixed_res.trend_l2_miss = zpcd_pkg::TREND_STABLE;
		rows.insert(rows.size(), row);
		row.has_fixed = 1'b0;
		row.fixed_res = none;
		row.it = make_item('1, '1, '1, 32'hFFFF_FFFF, 16'hFFFF);
		rows.insert(rows.size(), row);
		row.it = make_item('0, '1, 24'h00_0001, 32'h5555_5555, 16'hAAAA);
		rows.insert(rows.size(), row);
		// ramps up, down and flat to reach the increasing, decreasing and stable trend codes
		for (int k = 0; k < 9; k++) begin
			row.it = make_item(IN_W'(100 + k * 7), IN_W'(32'hF0_0000 - k * 1000), 24'd4242,
				32'hAAAA_AAAA ^ 32'(k), 16'(32'h5555 ^ k));
			rows.insert(rows.size(), row);
		end
		// flat values on every channel, then a sudden jump
		for (int k = 0; k < 4; k++) begin
			row.it = make_item(24'd4242, 24'd4242, 24'd4242, 32'(k), 16'(k));
			rows.insert(rows.size(), row);
		end
		row.it = make_item(24'hFF_FFFF, 24'd0, 24'h80_0000, 32'h8000_0000, 16'h8000);
		rows.insert(rows.size(), row);
		foreach (rows[r])
			send_sample(rows[r].it, rows[r].has_fixed, rows[r].fixed_res);

		// sender pauses until everything is back, then settings change between phases
		wait_drained();
		thr_set = '{15'd0, 15'd32767, 15'd256, 15'd768, 15'd1, 15'd0};
		wl_set  = '{15'd0, 15'd1, 15'd2, 15'd64, 15'd127, 15'd8};
		n_sent = 0;
		for (int ph = 0; n_sent < 1750; ph++) begin
			if (ph < 6) begin
				write_reg(zpcd_pkg::CFG_Z_THRESHOLD, thr_set[ph]);
				write_reg(zpcd_pkg::CFG_WINDOW_LENGTH, wl_set[ph]);
			end else begin
				write_reg(zpcd_pkg::CFG_Z_THRESHOLD, $urandom_range(0, 2) == 0 ?
					15'($urandom) : 15'($urandom_range(0, 1500)));
				write_reg(zpcd_pkg::CFG_WINDOW_LENGTH, $urandom_range(0, 3) == 0 ?
					15'($urandom_range(0, 127)) : 15'($urandom_range(2, 12)));
			end
			// no idling at all in the final stretch and in some random phases
			idle_off = (n_sent > 1500) || ($urandom_range(0, 5) == 0);
			if (ph == 2)
				hold_req = 1'b1;
			plen = (wlen_reg > 20) ? 40 : 120;
			// a phase: steady levels, then a shift and a mix of noise, ramps and random values
			for (int ch = 0; ch < NCH; ch++)
				lvl[ch] = IN_W'($urandom);
			noise_bits = $urandom_range(0, 20);
			for (int k = 0; k < plen; k++) begin
				kind = (k < plen / 2) ? 0 : $urandom_range(0, 3);
				if (k == plen / 2)
					for (int ch = 0; ch < NCH; ch++)
						lvl[ch] = lvl[ch] + IN_W'($urandom_range(0, 1 << 22));
				for (int ch = 0; ch < NCH; ch++) begin
					if (kind == 1)
						lvl[ch] = lvl[ch] + IN_W'($urandom_range(1, 300));
					else if (kind == 2)
						lvl[ch] = lvl[ch] - IN_W'($urandom_range(1, 300));
				end
				send_sample(make_item(phase_sample(kind, lvl[0], noise_bits, 0),
					phase_sample(kind, lvl[1], noise_bits, 0),
					phase_sample(kind, lvl[2], noise_bits, 0),
					$urandom, 16'($urandom)), 1'b0, none);
				n_sent++;
			end
			wait_drained();
		end

		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
